// ===== hdl/vvpu_pkg.sv =====
// Shared types, codes and saturation helpers for the velocity Verlet update unit.
package vvpu_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 31;
    localparam int IMG_W  = 16;
    localparam int PROD_W = 64;
    localparam int QUO_W  = 32;
    localparam int K_W    = 34;
    localparam int ADDR_W = 4;

    localparam logic [1:0] OP_FIRST_HALF  = 2'd0;
    localparam logic [1:0] OP_SECOND_HALF = 2'd1;
    localparam logic [1:0] OP_SCALAR      = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] REG_HALF_STEP = 2'd0;
    localparam logic [1:0] REG_BOX_X     = 2'd1;
    localparam logic [1:0] REG_BOX_Y     = 2'd2;
    localparam logic [1:0] REG_BOX_Z     = 2'd3;

    localparam logic [QUO_W-1:0] QUO_LIMIT = 32'h8000_0000;

    localparam logic signed [PROD_W-1:0] SAT32_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT32_MIN = -64'sd2147483648;
    localparam logic signed [PROD_W-1:0] SAT16_MAX = 64'sd32767;
    localparam logic signed [PROD_W-1:0] SAT16_MIN = -64'sd32768;

    // One item as it moves down the pipeline
    typedef struct packed {
        logic [1:0]               op;
        logic [1:0]               axis;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] acc;
        logic [LEN_W-1:0]         mass;
        logic signed [IMG_W-1:0]  img;
        logic signed [DATA_W-1:0] scal;
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] nvel;
        logic signed [DATA_W-1:0] npos;
        logic signed [DATA_W-1:0] nscal;
        logic signed [DATA_W-1:0] nacc;
        logic signed [IMG_W-1:0]  nimg;
        logic signed [K_W-1:0]    kimg;
        logic                     sh_neg;
        logic                     wrap;
        logic                     ovf;
        logic                     mzero;
        logic                     flag;
        logic [LEN_W-1:0]         rem;
        logic [DATA_W-1:0]        dvd;
        logic [QUO_W-1:0]         quo;
        logic [LEN_W-1:0]         dsr;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } t_sat32;

    typedef struct packed {
        logic signed [IMG_W-1:0] val;
        logic                    sat;
    } t_sat16;

    function automatic t_sat32 f_sat32(input logic signed [PROD_W-1:0] x);
        t_sat32 r;
        if (x > SAT32_MAX) begin
            r.val = SAT32_MAX[DATA_W-1:0];
            r.sat = 1'b1;
        end else if (x < SAT32_MIN) begin
            r.val = SAT32_MIN[DATA_W-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = x[DATA_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat16 f_sat16(input logic signed [PROD_W-1:0] x);
        t_sat16 r;
        if (x > SAT16_MAX) begin
            r.val = SAT16_MAX[IMG_W-1:0];
            r.sat = 1'b1;
        end else if (x < SAT16_MIN) begin
            r.val = SAT16_MIN[IMG_W-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = x[IMG_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] f_box_len(
        input logic [1:0]       axis,
        input logic [LEN_W-1:0] bx,
        input logic [LEN_W-1:0] by,
        input logic [LEN_W-1:0] bz
    );
        logic [LEN_W-1:0] len;
        case (axis)
            AXIS_X:  len = bx;
            AXIS_Y:  len = by;
            AXIS_Z:  len = bz;
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/vvpu_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
module vvpu_div_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  vvpu_pkg::t_item i_item,
    output logic            o_valid,
    output vvpu_pkg::t_item o_item
);
    import vvpu_pkg::*;

    localparam int STEPS = QUO_W;

    logic  r_valid [STEPS];
    t_item r_item  [STEPS];
    logic  w_src_v [STEPS];
    t_item w_src   [STEPS];
    t_item n_item  [STEPS];

    assign w_src[0]   = i_item;
    assign w_src_v[0] = i_valid;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [DATA_W-1:0] w_trial;
        logic [DATA_W:0]   w_diff;

        if (g > 0) begin : g_link
            assign w_src[g]   = r_item[g-1];
            assign w_src_v[g] = r_valid[g-1];
        end

        // shift in the next dividend bit and try the subtract
        assign w_trial = {w_src[g].rem, w_src[g].dvd[DATA_W-1]};
        assign w_diff  = {1'b0, w_trial} - {2'b0, w_src[g].dsr};

        always_comb begin
            n_item[g]     = w_src[g];
            n_item[g].rem = w_diff[DATA_W] ? w_trial[LEN_W-1:0] : w_diff[LEN_W-1:0];
            n_item[g].dvd = {w_src[g].dvd[DATA_W-2:0], 1'b0};
            n_item[g].quo = {w_src[g].quo[QUO_W-2:0], ~w_diff[DATA_W]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_adv) begin
                r_valid[g] <= w_src_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[g] <= n_item[g];
            end
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_item  = r_item[STEPS-1];

endmodule

// ===== hdl/velocity_verlet_particle_update_unit.sv =====
// Top level of the velocity Verlet half-step particle update unit.
//
// Usage: program the half step and the three box lengths over the APB port
// (byte addresses 0, 4, 8, 12) while no item is in flight. Items then stream
// in on the valid/ready input channel, one axis of one particle or one scalar
// per transfer, and each produces exactly one result on the output channel.
// A new item can be taken in every cycle while no finished result waits
// untaken. The depth is set by the 32-stage restoring divider, which
// produces one quotient bit per stage and serves both the force over mass
// quotient and the periodic box wrap.
// Around it sit two multiply/add pairs in front, a divider setup stage, and
// three stages behind (quotient fixup, multiply, add and output register).
// Reset clears the configuration registers and every valid bit; data
// registers are not cleared. When the receiver holds i_out_ready low with a
// result waiting, the whole pipeline holds in place and o_in_ready drops;
// nothing is lost or repeated and transfers resume when the result is taken.
module velocity_verlet_particle_update_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vvpu_pkg::ADDR_W-1:0]     paddr,
    input  logic [vvpu_pkg::DATA_W-1:0]     pwdata,
    output logic [vvpu_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic [1:0]                      i_axis,
    input  logic signed [vvpu_pkg::DATA_W-1:0] i_position,
    input  logic signed [vvpu_pkg::DATA_W-1:0] i_velocity,
    input  logic signed [vvpu_pkg::DATA_W-1:0] i_accel_or_force,
    input  logic [vvpu_pkg::LEN_W-1:0]      i_mass,
    input  logic signed [vvpu_pkg::IMG_W-1:0]  i_image_count,
    input  logic signed [vvpu_pkg::DATA_W-1:0] i_scalar_value,
    input  logic signed [vvpu_pkg::DATA_W-1:0] i_scalar_rate,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [vvpu_pkg::DATA_W-1:0] o_new_position,
    output logic signed [vvpu_pkg::DATA_W-1:0] o_new_velocity,
    output logic signed [vvpu_pkg::DATA_W-1:0] o_new_acceleration,
    output logic signed [vvpu_pkg::IMG_W-1:0]  o_new_image_count,
    output logic signed [vvpu_pkg::DATA_W-1:0] o_new_scalar,
    output logic                            o_error_flag
);
    import vvpu_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;

    // configuration
    logic [LEN_W-1:0] r_half_step;
    logic [LEN_W-1:0] r_box_x;
    logic [LEN_W-1:0] r_box_y;
    logic [LEN_W-1:0] r_box_z;
    logic             w_cfg_wr;

    // pipeline
    logic  w_adv;
    logic  r_v_s1, r_v_s2, r_v_s3, r_v_s4, r_v_s5, r_v_p1, r_v_p2, r_v_p3;
    t_item r_s1, r_s2, r_s3, r_s4, r_s5, r_p1, r_p2, r_p3;
    t_item n_s1, n_s2, n_s3, n_s4, n_s5, n_p1, n_p2, n_p3;
    logic  w_div_valid;
    t_item w_div_item;

    logic signed [DATA_W-1:0] w_h;
    logic signed [DATA_W-1:0] w_mul_a;
    logic signed [PROD_W-1:0] w_sum_s2, w_sum_s4, w_sum_p3, w_img_sum;
    t_sat32                   w_sat_s2, w_sat_s4, w_sat_p3, w_sat_acc;
    t_sat16                   w_sat_img;

    logic [LEN_W-1:0]         w_len_s4;
    logic signed [K_W-1:0]    w_sh;
    logic signed [K_W-1:0]    w_sh_abs;
    logic [DATA_W-1:0]        w_mag;
    logic [NUM_W-1:0]         w_num;
    logic [FRAC_BITS-1:0]     w_num_hi;
    logic [DATA_W-1:0]        w_num_hi32;

    logic [LEN_W-1:0]         w_len_d;
    logic                     w_rem_nz;
    logic [LEN_W-1:0]         w_wrap_base;
    logic signed [DATA_W-1:0] w_wrap_pos;
    logic [K_W-1:0]           w_kmag;
    logic [QUO_W-1:0]         w_qclamp;
    logic signed [QUO_W:0]    w_qsgn;

    // ---------------------------------------------------------------- APB
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_step <= '0;
            r_box_x     <= '0;
            r_box_y     <= '0;
            r_box_z     <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_HALF_STEP: r_half_step <= pwdata[LEN_W-1:0];
                REG_BOX_X:     r_box_x     <= pwdata[LEN_W-1:0];
                REG_BOX_Y:     r_box_y     <= pwdata[LEN_W-1:0];
                REG_BOX_Z:     r_box_z     <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HALF_STEP: prdata = {1'b0, r_half_step};
            REG_BOX_X:     prdata = {1'b0, r_box_x};
            REG_BOX_Y:     prdata = {1'b0, r_box_y};
            REG_BOX_Z:     prdata = {1'b0, r_box_z};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- flow control
    // hold every stage while a finished result waits
    assign w_adv      = ~r_v_p3 | i_out_ready;
    assign o_in_ready = w_adv;
    assign w_h        = $signed({1'b0, r_half_step});

    // s1: capture the transfer and form the first product
    always_comb begin
        n_s1      = '0;
        n_s1.op   = i_operation;
        n_s1.axis = i_axis;
        n_s1.pos  = i_position;
        n_s1.vel  = i_velocity;
        n_s1.acc  = i_accel_or_force;
        n_s1.mass = i_mass;
        n_s1.img  = i_image_count;
        n_s1.scal = i_scalar_value;
        case (i_operation)
            OP_FIRST_HALF:  w_mul_a = i_accel_or_force;
            OP_SECOND_HALF: w_mul_a = i_velocity;
            OP_SCALAR:      w_mul_a = i_scalar_rate;
            default: begin
                w_mul_a   = '0;
                n_s1.flag = 1'b1;
            end
        endcase
        n_s1.prod = PROD_W'(w_mul_a) * PROD_W'(w_h);
    end

    // s2: first add; new velocity, drifted position or new scalar
    always_comb begin
        n_s2 = r_s1;
        case (r_s1.op)
            OP_FIRST_HALF:  w_sum_s2 = PROD_W'($signed(r_s1.vel));
            OP_SECOND_HALF: w_sum_s2 = PROD_W'($signed(r_s1.pos));
            OP_SCALAR:      w_sum_s2 = PROD_W'($signed(r_s1.scal));
            default:        w_sum_s2 = '0;
        endcase
        w_sum_s2 = w_sum_s2 + ($signed(r_s1.prod) >>> FRAC_BITS);
        w_sat_s2 = f_sat32(w_sum_s2);
        case (r_s1.op)
            OP_FIRST_HALF: begin
                n_s2.nvel = w_sat_s2.val;
                n_s2.flag = r_s1.flag | w_sat_s2.sat;
            end
            OP_SECOND_HALF: begin
                n_s2.npos = w_sat_s2.val;
                n_s2.flag = r_s1.flag | w_sat_s2.sat;
            end
            OP_SCALAR: begin
                n_s2.nscal = w_sat_s2.val;
                n_s2.flag  = r_s1.flag | w_sat_s2.sat;
            end
            default: ;
        endcase
    end

    // s3: new velocity times half step
    always_comb begin
        n_s3      = r_s2;
        n_s3.prod = PROD_W'($signed(r_s2.nvel)) * PROD_W'(w_h);
    end

    // s4: drift the position with the new velocity
    always_comb begin
        n_s4     = r_s3;
        w_sum_s4 = PROD_W'($signed(r_s3.pos)) + ($signed(r_s3.prod) >>> FRAC_BITS);
        w_sat_s4 = f_sat32(w_sum_s4);
        if (r_s3.op == OP_FIRST_HALF) begin
            n_s4.npos = w_sat_s4.val;
            n_s4.flag = r_s3.flag | w_sat_s4.sat;
        end
    end

    // s5: load the divider, either |pos + L/2| by L or |F| << FRAC_BITS by m
    always_comb begin
        n_s5        = r_s4;
        w_len_s4    = f_box_len(r_s4.axis, r_box_x, r_box_y, r_box_z);
        w_sh        = $signed({{(K_W-DATA_W){r_s4.npos[DATA_W-1]}}, r_s4.npos})
                    + $signed({{(K_W-LEN_W+1){1'b0}}, w_len_s4[LEN_W-1:1]});
        w_sh_abs    = w_sh[K_W-1] ? -w_sh : w_sh;
        w_mag       = r_s4.acc[DATA_W-1] ? (~r_s4.acc + 32'd1) : r_s4.acc;
        w_num       = NUM_W'(w_mag) << FRAC_BITS;
        w_num_hi    = w_num[NUM_W-1:DATA_W];
        w_num_hi32  = DATA_W'(w_num_hi);
        n_s5.rem    = '0;
        n_s5.dvd    = '0;
        n_s5.dsr    = '0;
        n_s5.quo    = '0;
        n_s5.wrap   = 1'b0;
        n_s5.sh_neg = 1'b0;
        n_s5.ovf    = 1'b0;
        n_s5.mzero  = 1'b0;
        case (r_s4.op)
            OP_FIRST_HALF: begin
                n_s5.wrap   = (w_len_s4 != '0);
                n_s5.sh_neg = w_sh[K_W-1];
                n_s5.dvd    = w_sh_abs[DATA_W-1:0];
                n_s5.dsr    = w_len_s4;
            end
            OP_SECOND_HALF: begin
                n_s5.mzero = (r_s4.mass == '0);
                // quotient of 2^32 or more: clamp without dividing
                n_s5.ovf   = (w_num_hi32 >= {1'b0, r_s4.mass});
                n_s5.rem   = w_num_hi32[LEN_W-1:0];
                n_s5.dvd   = w_num[DATA_W-1:0];
                n_s5.dsr   = r_s4.mass;
            end
            default: ;
        endcase
    end

    vvpu_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v_s5),
        .i_item  (r_s5),
        .o_valid (w_div_valid),
        .o_item  (w_div_item)
    );

    // p1: floor wrap from quotient and remainder, or signed force over mass
    always_comb begin
        n_p1        = w_div_item;
        w_len_d     = f_box_len(w_div_item.axis, r_box_x, r_box_y, r_box_z);
        w_rem_nz    = (w_div_item.rem != '0);
        if (!w_div_item.sh_neg) begin
            w_wrap_base = w_div_item.rem;
        end else if (w_rem_nz) begin
            w_wrap_base = w_len_d - w_div_item.rem;
        end else begin
            w_wrap_base = '0;
        end
        w_wrap_pos  = $signed({1'b0, w_wrap_base})
                    - $signed({2'b0, w_len_d[LEN_W-1:1]});
        // negative shift with a remainder rounds the image count one further
        w_kmag      = {2'b0, w_div_item.quo} + {{(K_W-1){1'b0}}, w_rem_nz & w_div_item.sh_neg};
        w_qclamp    = (w_div_item.ovf || w_div_item.quo > QUO_LIMIT) ? QUO_LIMIT
                                                                    : w_div_item.quo;
        w_qsgn      = w_div_item.acc[DATA_W-1] ? -$signed({1'b0, w_qclamp})
                                               : $signed({1'b0, w_qclamp});
        w_sat_acc   = f_sat32(PROD_W'(w_qsgn));
        n_p1.kimg   = '0;
        case (w_div_item.op)
            OP_FIRST_HALF: begin
                if (w_div_item.wrap) begin
                    n_p1.npos = w_wrap_pos;
                    n_p1.kimg = w_div_item.sh_neg ? -$signed(w_kmag) : $signed(w_kmag);
                end
            end
            OP_SECOND_HALF: begin
                if (w_div_item.mzero) begin
                    n_p1.nacc = '0;
                    n_p1.flag = 1'b1;
                end else begin
                    n_p1.nacc = w_sat_acc.val;
                    n_p1.flag = w_div_item.flag | w_sat_acc.sat;
                end
            end
            default: ;
        endcase
    end

    // p2: acceleration times half step; image count update
    always_comb begin
        n_p2      = r_p1;
        n_p2.prod = PROD_W'($signed(r_p1.nacc)) * PROD_W'(w_h);
        w_img_sum = PROD_W'($signed(r_p1.img)) + PROD_W'($signed(r_p1.kimg));
        w_sat_img = f_sat16(w_img_sum);
        n_p2.nimg = r_p1.img;
        if (r_p1.op == OP_FIRST_HALF) begin
            n_p2.nimg = w_sat_img.val;
            n_p2.flag = r_p1.flag | w_sat_img.sat;
        end
    end

    // p3: kick the velocity and assemble the result
    always_comb begin
        n_p3     = r_p2;
        w_sum_p3 = PROD_W'($signed(r_p2.vel)) + ($signed(r_p2.prod) >>> FRAC_BITS);
        w_sat_p3 = f_sat32(w_sum_p3);
        case (r_p2.op)
            OP_FIRST_HALF: begin
                n_p3.nacc  = r_p2.acc;
                n_p3.nscal = '0;
            end
            OP_SECOND_HALF: begin
                n_p3.nvel  = w_sat_p3.val;
                n_p3.flag  = r_p2.flag | w_sat_p3.sat;
                n_p3.nscal = '0;
            end
            OP_SCALAR: begin
                n_p3.npos = '0;
                n_p3.nvel = '0;
                n_p3.nimg = '0;
                n_p3.nacc = r_p2.acc;
            end
            default: begin
                n_p3.npos  = '0;
                n_p3.nvel  = '0;
                n_p3.nacc  = '0;
                n_p3.nimg  = '0;
                n_p3.nscal = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s1 <= 1'b0;
            r_v_s2 <= 1'b0;
            r_v_s3 <= 1'b0;
            r_v_s4 <= 1'b0;
            r_v_s5 <= 1'b0;
            r_v_p1 <= 1'b0;
            r_v_p2 <= 1'b0;
            r_v_p3 <= 1'b0;
        end else if (w_adv) begin
            r_v_s1 <= i_in_valid;
            r_v_s2 <= r_v_s1;
            r_v_s3 <= r_v_s2;
            r_v_s4 <= r_v_s3;
            r_v_s5 <= r_v_s4;
            r_v_p1 <= w_div_valid;
            r_v_p2 <= r_v_p1;
            r_v_p3 <= r_v_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
        end
    end

    assign o_out_valid        = r_v_p3;
    assign o_new_position     = r_p3.npos;
    assign o_new_velocity     = r_p3.nvel;
    assign o_new_acceleration = r_p3.nacc;
    assign o_new_image_count  = r_p3.nimg;
    assign o_new_scalar       = r_p3.nscal;
    assign o_error_flag       = r_p3.flag;

endmodule

// ===== tb/velocity_verlet_particle_update_unit_test.sv =====
// Self-checking testbench for the velocity Verlet half-step update unit.
`timescale 1ns / 100ps

module velocity_verlet_particle_update_unit_test;
    import vvpu_pkg::*;

    localparam int FRAC = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         axis;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] af;
        logic [30:0]        mass;
        logic signed [15:0] img;
        logic signed [31:0] sval;
        logic signed [31:0] srate;
    } particle_in_t;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic signed [31:0] new_acceleration;
        logic signed [15:0] new_image_count;
        logic signed [31:0] new_scalar;
        logic               error_flag;
    } particle_out_t;

    class verlet_scoreboard;
        particle_out_t pending_updates[$];
        logic [30:0]   half_step;
        logic [30:0]   box_x;
        logic [30:0]   box_y;
        logic [30:0]   box_z;
        logic          overflow;
        int            accepted;
        int            checked;
        int            flagged;
        int            errors;

        function new();
            half_step = '0;
            box_x = '0;
            box_y = '0;
            box_z = '0;
            accepted = 0;
            checked = 0;
            flagged = 0;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_HALF_STEP: half_step = value[30:0];
                REG_BOX_X:     box_x = value[30:0];
                REG_BOX_Y:     box_y = value[30:0];
                REG_BOX_Z:     box_z = value[30:0];
                default: ;
            endcase
        endfunction

        // x*h in fixed point, rounded toward minus infinity
        function logic signed [63:0] scale(logic signed [63:0] x);
            logic signed [63:0] h;
            h = $signed({33'd0, half_step});
            return (x * h) >>> FRAC;
        endfunction

        function logic signed [63:0] clamp(logic signed [63:0] x, int bits);
            logic signed [63:0] hi;
            logic signed [63:0] lo;
            hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (x > hi) begin
                overflow = 1'b1;
                return hi;
            end
            if (x < lo) begin
                overflow = 1'b1;
                return lo;
            end
            return x;
        endfunction

        function particle_out_t integrate(particle_in_t it);
            particle_out_t      r;
            logic signed [63:0] len;
            logic signed [63:0] pos;
            logic signed [63:0] vel;
            logic signed [63:0] acc;
            logic signed [63:0] sh;
            logic signed [63:0] k;
            logic signed [63:0] t;
            logic [63:0]        mag;
            logic [63:0]        quo;
            r = '0;
            overflow = 1'b0;
            case (it.op)
                OP_FIRST_HALF: begin
                    case (it.axis)
                        AXIS_X:  len = $signed({33'd0, box_x});
                        AXIS_Y:  len = $signed({33'd0, box_y});
                        AXIS_Z:  len = $signed({33'd0, box_z});
                        default: len = 64'sd0;
                    endcase
                    r.new_acceleration = it.af;
                    vel = clamp($signed(it.vel) + scale($signed(it.af)), 32);
                    pos = clamp($signed(it.pos) + scale(vel), 32);
                    r.new_image_count = it.img;
                    if (len != 64'sd0) begin
                        // bring the coordinate into [-L/2, L - L/2) with floor division
                        sh = pos + (len >>> 1);
                        if (sh >= 64'sd0)
                            k = sh / len;
                        else
                            k = -((-sh + len - 64'sd1) / len);
                        pos = pos - k * len;
                        t = clamp($signed(it.img) + k, 16);
                        r.new_image_count = t[15:0];
                    end
                    r.new_position = pos[31:0];
                    r.new_velocity = vel[31:0];
                end
                OP_SECOND_HALF: begin
                    if (it.mass == '0) begin
                        acc = 64'sd0;
                        overflow = 1'b1;
                    end else begin
                        acc = $signed(it.af);
                        mag = (acc < 64'sd0) ? -acc : acc;
                        quo = (mag << FRAC) / {33'd0, it.mass};
                        if (quo > 64'h8000_0000)
                            quo = 64'h8000_0000;
                        acc = (acc < 64'sd0) ? -$signed(quo) : $signed(quo);
                        acc = clamp(acc, 32);
                    end
                    pos = clamp($signed(it.pos) + scale($signed(it.vel)), 32);
                    vel = clamp($signed(it.vel) + scale(acc), 32);
                    r.new_position = pos[31:0];
                    r.new_velocity = vel[31:0];
                    r.new_acceleration = acc[31:0];
                    r.new_image_count = it.img;
                end
                OP_SCALAR: begin
                    r.new_acceleration = it.af;
                    t = clamp($signed(it.sval) + scale($signed(it.srate)), 32);
                    r.new_scalar = t[31:0];
                end
                default: overflow = 1'b1;
            endcase
            r.error_flag = overflow;
            return r;
        endfunction

        function void note_particle(particle_in_t it);
            particle_out_t want;
            want = integrate(it);
            pending_updates.push_back(want);
            accepted++;
            if (want.error_flag)
                flagged++;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s expected %h got %h", $time, name, want, got);
            end
        endfunction

        function void check_update(particle_out_t got);
            particle_out_t want;
            if (pending_updates.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result expected none got position %h scalar %h",
                             $time, got.new_position, got.new_scalar);
                return;
            end
            want = pending_updates.pop_front();
            checked++;
            compare("new_position", want.new_position, got.new_position);
            compare("new_velocity", want.new_velocity, got.new_velocity);
            compare("new_acceleration", want.new_acceleration, got.new_acceleration);
            compare("new_image_count", want.new_image_count, got.new_image_count);
            compare("new_scalar", want.new_scalar, got.new_scalar);
            compare("error_flag", want.error_flag, got.error_flag);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_operation = '0;
    logic [1:0]         i_axis = '0;
    logic signed [31:0] i_position = '0;
    logic signed [31:0] i_velocity = '0;
    logic signed [31:0] i_accel_or_force = '0;
    logic [30:0]        i_mass = '0;
    logic signed [15:0] i_image_count = '0;
    logic signed [31:0] i_scalar_value = '0;
    logic signed [31:0] i_scalar_rate = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_new_position;
    logic signed [31:0] o_new_velocity;
    logic signed [31:0] o_new_acceleration;
    logic signed [15:0] o_new_image_count;
    logic signed [31:0] o_new_scalar;
    logic               o_error_flag;

    logic               steady = 1'b0;
    int                 settings = 0;
    verlet_scoreboard   sb;

    velocity_verlet_particle_update_unit #(.FRAC_BITS(FRAC)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_axis(i_axis),
        .i_position(i_position),
        .i_velocity(i_velocity),
        .i_accel_or_force(i_accel_or_force),
        .i_mass(i_mass),
        .i_image_count(i_image_count),
        .i_scalar_value(i_scalar_value),
        .i_scalar_rate(i_scalar_rate),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_new_position(o_new_position),
        .o_new_velocity(o_new_velocity),
        .o_new_acceleration(o_new_acceleration),
        .o_new_image_count(o_new_image_count),
        .o_new_scalar(o_new_scalar),
        .o_error_flag(o_error_flag)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (steady)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 99) >= 28);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_particle('{i_operation, i_axis, i_position, i_velocity,
                                   i_accel_or_force, i_mass, i_image_count,
                                   i_scalar_value, i_scalar_rate});
            if (o_out_valid && i_out_ready)
                sb.check_update('{o_new_position, o_new_velocity, o_new_acceleration,
                                  o_new_image_count, o_new_scalar, o_error_flag});
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
    endtask

    task automatic apply_setting(input logic [31:0] h, input logic [31:0] bx,
                                 input logic [31:0] by, input logic [31:0] bz);
        write_register(REG_HALF_STEP, h);
        write_register(REG_BOX_X, bx);
        write_register(REG_BOX_Y, by);
        write_register(REG_BOX_Z, bz);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    task automatic send_item(input particle_in_t it);
        while (!steady && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= it.op;
        i_axis <= it.axis;
        i_position <= it.pos;
        i_velocity <= it.vel;
        i_accel_or_force <= it.af;
        i_mass <= it.mass;
        i_image_count <= it.img;
        i_scalar_value <= it.sval;
        i_scalar_rate <= it.srate;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold the sender until every pending update has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_updates.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic particle_in_t particle(
        logic [1:0] op, logic [1:0] axis, logic [31:0] p, logic [31:0] v,
        logic [31:0] a, logic [30:0] m, logic [15:0] img, logic [31:0] s,
        logic [31:0] r
    );
        particle_in_t it;
        it = '{op, axis, p, v, a, m, img, s, r};
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 32'h40_0000) - 32'h20_0000;
            7:          return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            8:          return $urandom_range(0, 32'h400) - 32'h200;
            default:    return '0;
        endcase
    endfunction

    function automatic logic [31:0] rand_box();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom_range(1, 32'h20_0000);
            2:       return $urandom_range(32'h1_0000, 32'h100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_in_t random_particle();
        particle_in_t it;
        int           sel;
        sel = $urandom_range(0, 99);
        it.op = (sel < 40) ? OP_FIRST_HALF : (sel < 70) ? OP_SECOND_HALF :
                (sel < 95) ? OP_SCALAR : OP_UNUSED;
        it.axis = ($urandom_range(0, 9) < 9) ? 2'($urandom_range(0, 2)) : AXIS_NONE;
        it.pos = rand_coord();
        it.vel = rand_coord();
        it.af = rand_coord();
        it.sval = rand_coord();
        it.srate = rand_coord();
        case ($urandom_range(0, 9))
            0:             it.mass = '0;
            1, 2, 3, 4, 5: it.mass = 31'($urandom_range(1, 32'h40_0000));
            6, 7, 8:       it.mass = 31'($urandom);
            default:       it.mass = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd1;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.img = 16'($urandom_range(0, 64) - 32);
            5, 6:          it.img = 16'(32767 - $urandom_range(0, 3));
            7:             it.img = 16'(-32768 + $urandom_range(0, 3));
            default:       it.img = 16'($urandom);
        endcase
        return it;
    endfunction

    initial begin : stimulus
        int          phase;
        int          n;
        logic [31:0] h;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // half step 0.5, box x 10.0, box y at its largest, z unwrapped
        apply_setting(32'h0000_8000, 32'h000A_0000, 32'h7FFF_FFFF, 32'h0);
        send_item(particle(OP_FIRST_HALF, AXIS_X, 0, 0, 0, 0, 0, 0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_Z, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h7FFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF));
        send_item(particle(OP_FIRST_HALF, AXIS_Z, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 0, 16'h8000, 32'h8000_0000, 32'h8000_0000));
        // exactly on the upper edge of the box, and on the lower edge
        send_item(particle(OP_FIRST_HALF, AXIS_X, 32'h0005_0000, 0, 0, 0, 0, 0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_X, 32'hFFFB_0000, 0, 0, 0, 0, 0, 0));
        // far outside the box, driving the image count into saturation
        send_item(particle(OP_FIRST_HALF, AXIS_X, 32'h03E8_0000, 0, 0, 0, 16'h7FFF, 0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_X, 32'hFC18_0000, 0, 0, 0, 16'h8000, 0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_Y, 32'h7FFF_FFFF, 32'h0001_0000, 0, 0, 3,
                           0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_NONE, 32'h4000_0000, 32'h0010_0000,
                           32'h0002_0000, 0, 5, 0, 0));
        send_item(particle(OP_FIRST_HALF, AXIS_X, 32'h0001_0000, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 0, 0, 0, 0));
        // zero mass, smallest mass with the largest forces, ordinary division
        send_item(particle(OP_SECOND_HALF, AXIS_X, 32'h0002_0000, 32'h0001_0000,
                           32'h0003_0000, 0, 7, 0, 0));
        send_item(particle(OP_SECOND_HALF, AXIS_Y, 0, 0, 32'h7FFF_FFFF, 1, 0, 0, 0));
        send_item(particle(OP_SECOND_HALF, AXIS_Z, 0, 0, 32'h8000_0000, 1, 0, 0, 0));
        send_item(particle(OP_SECOND_HALF, AXIS_X, 32'h0000_8000, 32'hFFFF_0000,
                           32'h0001_0000, 31'h0003_0000, 16'hFFFF, 0, 0));
        send_item(particle(OP_SECOND_HALF, AXIS_X, 32'hFFFF_FFF9, 32'h0000_0001,
                           32'hFFFF_FFF9, 31'h7FFF_FFFF, 0, 0, 0));
        send_item(particle(OP_SECOND_HALF, AXIS_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h0001_0000, 31'h0001_0000, 0, 0, 0));
        send_item(particle(OP_SCALAR, AXIS_X, 0, 0, 32'h1234_5678, 0, 0, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF));
        send_item(particle(OP_SCALAR, AXIS_Y, 0, 0, 0, 0, 0, 32'h8000_0000,
                           32'h8000_0000));
        send_item(particle(OP_SCALAR, AXIS_Z, 0, 0, 0, 0, 0, 32'h0001_0000, 32'hFFFF_FFFF));
        send_item(particle(OP_UNUSED, AXIS_X, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
                           31'h4444_4444, 16'h5555, 32'h6666_6666, 32'h7777_7777));

        for (phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: apply_setting(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1);
                1: apply_setting(32'h0, 32'h0, 32'h0, 32'h0);
                2: apply_setting(32'h1, 32'h1, 32'h2, 32'h3);
                default: begin
                    h = $urandom_range(0, 1) ? $urandom_range(1, 32'h4_0000) : $urandom;
                    apply_setting(h, rand_box(), rand_box(), rand_box());
                end
            endcase
            // one phase runs with both sides streaming back to back
            steady <= (phase == 4);
            for (n = 0; n < 165; n++) begin
                if (phase == 5 && n == 80)
                    drain();
                send_item(random_particle());
            end
        end
        drain();
        steady <= 1'b0;
        repeat (50) @(posedge i_clk);

        $display("%0d particle and scalar updates sent under %0d register settings",
                 sb.accepted, settings);
        $display("%0d results compared, %0d expected with the error flag, %0d mismatches",
                 sb.checked, sb.flagged, sb.errors);
        if (sb.errors == 0 && sb.pending_updates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
